// File: rtl/core/rrwd_pkg.sv
// Shared types and constants for the round-robin worker dispatcher.
// Used by rrwd_ctrl, rrwd_dp and round_robin_worker_dispatcher; no dependencies.
package rrwd_pkg;

	// item action codes
	localparam logic [1:0] ACT_DISPATCH = 2'd0;
	localparam logic [1:0] ACT_ADD      = 2'd1;
	localparam logic [1:0] ACT_REMOVE   = 2'd2;

	// result status codes
	localparam logic [2:0] ST_DISPATCHED = 3'd0;
	localparam logic [2:0] ST_NO_WORKER  = 3'd1;
	localparam logic [2:0] ST_ADDED      = 3'd2;
	localparam logic [2:0] ST_FULL       = 3'd3;
	localparam logic [2:0] ST_REMOVED    = 3'd4;
	localparam logic [2:0] ST_NOT_FOUND  = 3'd5;

	// list read address select
	localparam logic [1:0] RD_PTR  = 2'd0;
	localparam logic [1:0] RD_IDX  = 2'd1;
	localparam logic [1:0] RD_IDX1 = 2'd2;

	typedef struct packed {
		logic       capture;   // latch an accepted item
		logic       rd_en;     // read list entry into rdata
		logic [1:0] rd_sel;
		logic       add_wr;    // append worker, bump count
		logic       sh_wr;     // write rdata one slot down, step index
		logic       idx_inc;
		logic       hit_save;  // remember matching slot
		logic       rm_fin;    // shrink count, fix pointer
		logic       dsp_fin;   // dispatch result, advance pointer
		logic       set_res;   // load status code with zero payload
		logic [2:0] res_code;
		logic       out_load;
	} cmd_t;

	typedef struct packed {
		logic [1:0] act;
		logic       count_zero;
		logic       full;
		logic       match;
		logic       idx_last;  // idx + 1 >= count
		logic       out_free;
	} sts_t;

endpackage

// File: rtl/core/rrwd_dp.sv
// Datapath: item latch, worker list memory, count, round-robin pointer, result register.
// Depends on rrwd_pkg; driven by rrwd_ctrl through cmd_t, reports through sts_t.
module rrwd_dp #(
	parameter int MAX_WORKERS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  rrwd_pkg::cmd_t   cmd,
	output rrwd_pkg::sts_t   sts,
	input  logic [1:0]       action,
	input  logic [7:0]       worker_id,
	input  logic [15:0]      connection_id,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [2:0]       status,
	output logic [7:0]       chosen_worker,
	output logic [15:0]      connection_out
);

	localparam int IW = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
	localparam int CW = $clog2(MAX_WORKERS + 1);
	localparam logic [CW-1:0] MaxCount = CW'(MAX_WORKERS);

	logic [7:0]    mem [MAX_WORKERS];
	logic [1:0]    act_q;
	logic [7:0]    id_q;
	logic [15:0]   conn_q;
	logic [7:0]    rdata_q;
	logic [IW-1:0] idx_q;
	logic [IW-1:0] hit_q;
	logic [CW-1:0] count_q;
	logic [IW-1:0] ptr_q;
	logic [2:0]    res_st_q;
	logic [7:0]    res_wk_q;
	logic [15:0]   res_conn_q;
	logic          out_valid_q;
	logic [2:0]    status_q;
	logic [7:0]    chosen_q;
	logic [15:0]   conn_out_q;

	logic [IW-1:0] rd_addr;
	logic [IW-1:0] idx_nxt;
	logic [CW-1:0] idx_plus1;
	logic [CW-1:0] ptr_plus1;
	logic [CW-1:0] count_dec;
	logic [IW-1:0] ptr_rm;

	assign idx_plus1 = CW'(idx_q) + CW'(1);
	assign idx_nxt   = idx_plus1[IW-1:0];
	assign ptr_plus1 = CW'(ptr_q) + CW'(1);
	assign count_dec = count_q - CW'(1);
	assign ptr_rm    = (ptr_q > hit_q) ? ptr_q - IW'(1) : ptr_q;

	always_comb begin
		unique case (cmd.rd_sel)
			rrwd_pkg::RD_PTR:  rd_addr = ptr_q;
			rrwd_pkg::RD_IDX:  rd_addr = idx_q;
			rrwd_pkg::RD_IDX1: rd_addr = idx_nxt;
			default:           rd_addr = idx_q;
		endcase
	end

	always_comb begin
		sts.act        = act_q;
		sts.count_zero = (count_q == '0);
		sts.full       = (count_q >= MaxCount);
		sts.match      = (rdata_q == id_q);
		sts.idx_last   = (idx_plus1 >= count_q);
		sts.out_free   = !out_valid_q || out_ready;
	end

	// list memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.add_wr) begin
			mem[count_q[IW-1:0]] <= id_q;
		end else if (cmd.sh_wr) begin
			mem[idx_q] <= rdata_q;
		end
		if (cmd.rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	// item and result payload
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			act_q  <= action;
			id_q   <= worker_id;
			conn_q <= connection_id;
		end
		if (cmd.hit_save) begin
			hit_q <= idx_q;
		end
		if (cmd.dsp_fin) begin
			res_st_q   <= rrwd_pkg::ST_DISPATCHED;
			res_wk_q   <= rdata_q;
			res_conn_q <= conn_q;
		end else if (cmd.set_res) begin
			res_st_q   <= cmd.res_code;
			res_wk_q   <= '0;
			res_conn_q <= '0;
		end
		if (cmd.out_load) begin
			status_q   <= res_st_q;
			chosen_q   <= res_wk_q;
			conn_out_q <= res_conn_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			count_q     <= '0;
			ptr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.capture) begin
				idx_q <= '0;
			end else if (cmd.sh_wr || cmd.idx_inc) begin
				idx_q <= idx_nxt;
			end
			if (cmd.add_wr) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.rm_fin) begin
				count_q <= count_dec;
			end
			if (cmd.dsp_fin) begin
				ptr_q <= (ptr_plus1 >= count_q) ? '0 : ptr_plus1[IW-1:0];
			end else if (cmd.rm_fin) begin
				// pointer left at the list end wraps to the front
				ptr_q <= (CW'(ptr_rm) >= count_dec) ? '0 : ptr_rm;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign chosen_worker  = chosen_q;
	assign connection_out = conn_out_q;

endmodule

// File: rtl/core/rrwd_ctrl.sv
// Controller state machine: decodes an item and sequences list search, shift and result.
// Depends on rrwd_pkg; talks to rrwd_dp only through cmd_t and sts_t.
module rrwd_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  rrwd_pkg::sts_t sts,
	output rrwd_pkg::cmd_t cmd
);

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_DECODE   = 4'd1;
	localparam logic [3:0] S_DSP_FIN  = 4'd2;
	localparam logic [3:0] S_SRCH_RD  = 4'd3;
	localparam logic [3:0] S_SRCH_CMP = 4'd4;
	localparam logic [3:0] S_SH_RD    = 4'd5;
	localparam logic [3:0] S_SH_WR    = 4'd6;
	localparam logic [3:0] S_RM_FIN   = 4'd7;
	localparam logic [3:0] S_RESP     = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_nxt;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd       = '0;
		cmd.rd_sel = rrwd_pkg::RD_IDX;
		cmd.res_code = rrwd_pkg::ST_NO_WORKER;
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_nxt   = S_DECODE;
				end
			end
			S_DECODE: begin
				unique case (sts.act)
					rrwd_pkg::ACT_DISPATCH: begin
						if (sts.count_zero) begin
							cmd.set_res = 1'b1;
							state_nxt   = S_RESP;
						end else begin
							cmd.rd_en  = 1'b1;
							cmd.rd_sel = rrwd_pkg::RD_PTR;
							state_nxt  = S_DSP_FIN;
						end
					end
					rrwd_pkg::ACT_ADD: begin
						cmd.set_res = 1'b1;
						if (sts.full) begin
							cmd.res_code = rrwd_pkg::ST_FULL;
						end else begin
							cmd.add_wr   = 1'b1;
							cmd.res_code = rrwd_pkg::ST_ADDED;
						end
						state_nxt = S_RESP;
					end
					rrwd_pkg::ACT_REMOVE: begin
						if (sts.count_zero) begin
							cmd.set_res  = 1'b1;
							cmd.res_code = rrwd_pkg::ST_NOT_FOUND;
							state_nxt    = S_RESP;
						end else begin
							state_nxt = S_SRCH_RD;
						end
					end
					default: begin
						cmd.set_res = 1'b1;
						state_nxt   = S_RESP;
					end
				endcase
			end
			S_DSP_FIN: begin
				cmd.dsp_fin = 1'b1;
				state_nxt   = S_RESP;
			end
			S_SRCH_RD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = rrwd_pkg::RD_IDX;
				state_nxt  = S_SRCH_CMP;
			end
			S_SRCH_CMP: begin
				if (sts.match) begin
					cmd.hit_save = 1'b1;
					state_nxt    = S_SH_RD;
				end else if (sts.idx_last) begin
					cmd.set_res  = 1'b1;
					cmd.res_code = rrwd_pkg::ST_NOT_FOUND;
					state_nxt    = S_RESP;
				end else begin
					cmd.idx_inc = 1'b1;
					state_nxt   = S_SRCH_RD;
				end
			end
			S_SH_RD: begin
				// close the gap one entry at a time
				if (sts.idx_last) begin
					state_nxt = S_RM_FIN;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = rrwd_pkg::RD_IDX1;
					state_nxt  = S_SH_WR;
				end
			end
			S_SH_WR: begin
				cmd.sh_wr = 1'b1;
				state_nxt = S_SH_RD;
			end
			S_RM_FIN: begin
				cmd.rm_fin   = 1'b1;
				cmd.set_res  = 1'b1;
				cmd.res_code = rrwd_pkg::ST_REMOVED;
				state_nxt    = S_RESP;
			end
			S_RESP: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

// File: rtl/core/round_robin_worker_dispatcher.sv
// Round-robin worker dispatcher: keeps an ordered list of up to MAX_WORKERS worker ids in a
// register memory with one write port and one registered read port, and a round-robin pointer
// into it. An item is dispatch (hand connection_id to the worker at the pointer, then advance),
// add (append) or remove (delete first match and close the gap). One item is worked at a time;
// a result waits in an output register while the next item is taken. A result stalled at the
// output holds the controller in its response state. No clearing pass.
module round_robin_worker_dispatcher #(
	parameter int MAX_WORKERS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  action,
	input  logic [7:0]  worker_id,
	input  logic [15:0] connection_id,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [7:0]  chosen_worker,
	output logic [15:0] connection_out
);

	rrwd_pkg::cmd_t cmd;
	rrwd_pkg::sts_t sts;

	rrwd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	rrwd_dp #(
		.MAX_WORKERS (MAX_WORKERS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.action         (action),
		.worker_id      (worker_id),
		.connection_id  (connection_id),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.chosen_worker  (chosen_worker),
		.connection_out (connection_out)
	);

endmodule

// File: dv/round_robin_worker_dispatcher_tb.sv
// Testbench for round_robin_worker_dispatcher: directed list and pointer cases, then random
// add/remove/dispatch traffic under sender idling and receiver stalls, checked item by item.
// Depends on rrwd_pkg and the RTL of round_robin_worker_dispatcher.
`timescale 1ns / 100ps

module round_robin_worker_dispatcher_tb;

	localparam int LIST_DEPTH = 16;
	localparam logic [1:0] ACT_UNUSED = 2'd3;

	typedef struct packed {
		logic [2:0]  code;
		logic [7:0]  worker;
		logic [15:0] handle;
	} dispatch_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  action = rrwd_pkg::ACT_DISPATCH;
	logic [7:0]  worker_id = 8'h00;
	logic [15:0] connection_id = 16'h0000;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [2:0]  status;
	logic [7:0]  chosen_worker;
	logic [15:0] connection_out;

	// own copy of the worker list and round-robin pointer
	logic [7:0] roster [LIST_DEPTH];
	int         roster_len = 0;
	int         rr_slot = 0;

	dispatch_result_t expected_results [$];
	int fail_count = 0;
	int tx_idle_pct = 0;
	int rx_stall_pct = 0;
	int rx_hold_cycles = 0;

	round_robin_worker_dispatcher #(
		.MAX_WORKERS(LIST_DEPTH)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.action(action),
		.worker_id(worker_id),
		.connection_id(connection_id),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.chosen_worker(chosen_worker),
		.connection_out(connection_out)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic dispatch_result_t apply_worker_item(logic [1:0] act, logic [7:0] id,
			logic [15:0] conn);
		dispatch_result_t r;
		int hit;
		r.code = rrwd_pkg::ST_NO_WORKER;
		r.worker = 8'h00;
		r.handle = 16'h0000;
		hit = -1;
		case (act)
			rrwd_pkg::ACT_DISPATCH: begin
				if (roster_len != 0) begin
					if (rr_slot >= roster_len)
						rr_slot = 0;
					r.code = rrwd_pkg::ST_DISPATCHED;
					r.worker = roster[rr_slot];
					r.handle = conn;
					rr_slot++;
					if (rr_slot >= roster_len)
						rr_slot = 0;
				end
			end
			rrwd_pkg::ACT_ADD: begin
				if (roster_len >= LIST_DEPTH) begin
					r.code = rrwd_pkg::ST_FULL;
				end else begin
					roster[roster_len] = id;
					roster_len++;
					r.code = rrwd_pkg::ST_ADDED;
				end
			end
			rrwd_pkg::ACT_REMOVE: begin
				for (int i = 0; i < roster_len; i++)
					if (hit < 0 && roster[i] == id)
						hit = i;
				if (hit < 0) begin
					r.code = rrwd_pkg::ST_NOT_FOUND;
				end else begin
					for (int k = hit; k < roster_len - 1; k++)
						roster[k] = roster[k + 1];
					roster_len--;
					if (rr_slot > hit)
						rr_slot--;
					if (rr_slot >= roster_len)
						rr_slot = 0;
					r.code = rrwd_pkg::ST_REMOVED;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	// one item: optional idle cycles, then hold valid until accepted
	task automatic send_item(input logic [1:0] act, input logic [7:0] id,
			input logic [15:0] conn);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		worker_id <= id;
		connection_id <= conn;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		expected_results.push_back(apply_worker_item(act, id, conn));
	endtask

	task automatic wait_for_results();
		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
	endtask

	// grow phases favour adds, shrink phases favour removes of ids on the list
	task automatic send_random_item(input bit grow);
		int pick;
		logic [1:0] act;
		logic [7:0] id;
		pick = $urandom_range(99);
		id = $urandom_range(1) ? 8'($urandom_range(15)) : 8'($urandom);
		if (pick < 3)
			act = ACT_UNUSED;
		else if (pick < 28)
			act = rrwd_pkg::ACT_DISPATCH;
		else if (pick < (grow ? 88 : 40))
			act = rrwd_pkg::ACT_ADD;
		else
			act = rrwd_pkg::ACT_REMOVE;
		if (act == rrwd_pkg::ACT_REMOVE && roster_len != 0 && $urandom_range(3) != 0)
			id = roster[$urandom_range(roster_len - 1)];
		send_item(act, id, 16'($urandom));
	endtask

	always @(posedge clk) begin
		if (rx_hold_cycles > 0) begin
			out_ready <= 1'b0;
			rx_hold_cycles--;
		end else begin
			out_ready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	always @(posedge clk) begin
		dispatch_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result: expected none, got status %0d worker %0d conn %0d",
					$time, status, chosen_worker, connection_out);
				fail_count++;
			end else begin
				want = expected_results.pop_front();
				if (status !== want.code) begin
					$display("%0t: status: expected %0d, got %0d", $time, want.code, status);
					fail_count++;
				end
				if (chosen_worker !== want.worker) begin
					$display("%0t: chosen_worker: expected %0d, got %0d", $time, want.worker,
						chosen_worker);
					fail_count++;
				end
				if (connection_out !== want.handle) begin
					$display("%0t: connection_out: expected %0d, got %0d", $time, want.handle,
						connection_out);
					fail_count++;
				end
			end
		end
	end

	task automatic test_empty_list();
		send_item(rrwd_pkg::ACT_DISPATCH, 8'h00, 16'hFFFF);
		send_item(rrwd_pkg::ACT_REMOVE, 8'hFF, 16'h0000);
		send_item(ACT_UNUSED, 8'hFF, 16'hFFFF);
	endtask

	task automatic test_pointer_rules();
		send_item(rrwd_pkg::ACT_ADD, 8'h00, 16'h0000);
		send_item(rrwd_pkg::ACT_ADD, 8'hFF, 16'h0000);
		send_item(rrwd_pkg::ACT_ADD, 8'hFF, 16'hFFFF);       // duplicate id
		send_item(rrwd_pkg::ACT_DISPATCH, 8'hFF, 16'hFFFF);
		send_item(rrwd_pkg::ACT_DISPATCH, 8'h00, 16'h5A5A);
		send_item(rrwd_pkg::ACT_REMOVE, 8'hFF, 16'h0000);    // first match only, pointer steps back
		send_item(rrwd_pkg::ACT_DISPATCH, 8'h00, 16'hA5A5);  // wraps at list end
		send_item(rrwd_pkg::ACT_DISPATCH, 8'h00, 16'h1234);
		send_item(rrwd_pkg::ACT_REMOVE, 8'hFF, 16'h0000);    // pointer left at end, wraps to zero
		send_item(rrwd_pkg::ACT_REMOVE, 8'h55, 16'h0000);    // absent id
	endtask

	task automatic test_full_list();
		for (int k = 0; k < LIST_DEPTH - 1; k++)
			send_item(rrwd_pkg::ACT_ADD, 8'(k * 17 + 1), 16'h0000);
		send_item(rrwd_pkg::ACT_ADD, 8'hAA, 16'h0000);
		send_item(rrwd_pkg::ACT_DISPATCH, 8'h00, 16'h0000);
	endtask

	task automatic test_random_traffic(input int tx_pct, input int rx_pct, input int n_items);
		tx_idle_pct = tx_pct;
		rx_stall_pct = rx_pct;
		for (int i = 0; i < n_items; i++)
			send_random_item(((i / 40) % 2) == 0);
	endtask

	// receiver holds off while items keep coming, so the input stalls
	task automatic test_backpressure();
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		rx_hold_cycles = 300;
		for (int i = 0; i < 40; i++)
			send_random_item(i < 20);
		wait_for_results();
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_list();
		test_pointer_rules();
		test_full_list();
		test_random_traffic(0, 0, 325);
		test_backpressure();
		test_random_traffic(66, 0, 325);
		test_random_traffic(0, 66, 325);
		test_random_traffic(21, 21, 325);
		wait_for_results();
		repeat (60) @(posedge clk);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
